// ===== rtl/core/b64e_pkg.sv =====
// ---------------------------------------------------------------------------
// b64e_pkg
// Shared types, character constants and the Base64 symbol lookup.
// ---------------------------------------------------------------------------
`default_nettype none

package b64e_pkg;

  localparam logic [7:0] CHAR_PAD    = 8'h3D;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] WRAP_RESET  = 8'd19;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Register indexes on the configuration port.
  localparam logic REG_WRAP_GROUPS = 1'b0;

  typedef enum logic [2:0] {
    PH_0 = 3'b001,
    PH_1 = 3'b010,
    PH_2 = 3'b100
  } phase_e;

  // One accepted byte becomes one command: up to four characters, the index of
  // the final one, and whether that final character ends the message.
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      cnt_m1;
    logic            last;
  } cmd_t;

  function automatic logic [7:0] b64_sym(input logic [5:0] v);
    logic [7:0] c;
    c = 8'h00;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/base64_stream_encoder.sv =====
// ---------------------------------------------------------------------------
// base64_stream_encoder
// Streaming Base64 encoder with optional CR LF line wrapping.
// ---------------------------------------------------------------------------
// One message byte is taken per transaction and one character leaves per
// cycle while out_stall_i is low. A byte yields one to four characters (a
// symbol, two symbols, the symbols and pad of a message tail, or two symbols
// followed by CR LF). The output serializer sets the throughput; a two-entry
// command queue lets bytes keep arriving while characters drain, and input
// stalls only when that queue is full. The wrap_groups register (address 0,
// reset 19) sets complete groups per line; zero turns wrapping off.
`default_nettype none

module base64_stream_encoder import b64e_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_message_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_char_o,
  output logic             last_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [7:0] wrap_groups_q;
  logic       cfg_wr;
  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_empty;
  cmd_t       push_cmd;
  cmd_t       head_cmd;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_WRAP_GROUPS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_groups_q <= WRAP_RESET;
    end else if (cfg_wr) begin
      wrap_groups_q <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_WRAP_GROUPS) ? {24'd0, wrap_groups_q} : 32'd0;

  assign in_stall_o = q_full;
  assign push       = in_valid_i && !q_full;

  b64e_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .wrap_groups_i   (wrap_groups_q),
    .push_i          (push),
    .data_byte_i     (data_byte_i),
    .end_of_message_i(end_of_message_i),
    .cmd_o           (push_cmd)
  );

  b64e_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_cmd_i(push_cmd),
    .pop_i     (pop),
    .head_o    (head_cmd),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  b64e_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head_cmd),
    .empty_i    (q_empty),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_char_o (out_char_o),
    .last_o     (last_o)
  );

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty)
    else $error("command popped from an empty queue");

  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !q_empty)
    else $error("queue reports full and empty together");

  a_last_follows_eom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (push_cmd.last == end_of_message_i))
    else $error("command end mark differs from the message end");

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> (wrap_groups_q == $past(pwdata[7:0])))
    else $error("wrap_groups not updated by a register write");

endmodule

`default_nettype wire

// ===== rtl/core/b64e_front.sv =====
// ---------------------------------------------------------------------------
// b64e_front
// Accepts message bytes, tracks the group phase and line position, and turns
// each byte into a character command for the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module b64e_front import b64e_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] wrap_groups_i,
  input  wire logic       push_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       end_of_message_i,
  output cmd_t            cmd_o
);

  phase_e     phase_q, phase_d;
  logic [3:0] held_q, held_d;
  logic [7:0] line_q, line_d;
  logic [7:0] line_inc;
  cmd_t       cmd;

  assign line_inc = line_q + 8'd1;

  always_comb begin
    phase_d    = phase_q;
    held_d     = held_q;
    line_d     = line_q;
    cmd.chars  = '0;
    cmd.cnt_m1 = 2'd0;
    cmd.last   = end_of_message_i;
    case (phase_q)
      PH_1: begin
        cmd.chars[0] = b64_sym({held_q[1:0], data_byte_i[7:4]});
        cmd.chars[1] = b64_sym({data_byte_i[3:0], 2'b00});
        cmd.chars[2] = CHAR_PAD;
        cmd.cnt_m1   = end_of_message_i ? 2'd2 : 2'd0;
        held_d       = data_byte_i[3:0];
        phase_d      = PH_2;
      end
      PH_2: begin
        cmd.chars[0] = b64_sym({held_q, data_byte_i[7:6]});
        cmd.chars[1] = b64_sym(data_byte_i[5:0]);
        cmd.chars[2] = CHAR_CR;
        cmd.chars[3] = CHAR_LF;
        cmd.cnt_m1   = 2'd1;
        held_d       = 4'd0;
        phase_d      = PH_0;
        if (wrap_groups_i != 8'd0) begin
          if (line_inc >= wrap_groups_i) begin
            cmd.cnt_m1 = 2'd3;
            line_d     = 8'd0;
          end else begin
            line_d = line_inc;
          end
        end else begin
          line_d = 8'd0;
        end
      end
      default: begin
        cmd.chars[0] = b64_sym(data_byte_i[7:2]);
        cmd.chars[1] = b64_sym({data_byte_i[1:0], 4'b0000});
        cmd.chars[2] = CHAR_PAD;
        cmd.chars[3] = CHAR_PAD;
        cmd.cnt_m1   = end_of_message_i ? 2'd3 : 2'd0;
        held_d       = {2'b00, data_byte_i[1:0]};
        phase_d      = PH_1;
      end
    endcase
    if (end_of_message_i) begin
      phase_d = PH_0;
      held_d  = 4'd0;
      line_d  = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_0;
      held_q  <= 4'd0;
      line_q  <= 8'd0;
    end else if (push_i) begin
      phase_q <= phase_d;
      held_q  <= held_d;
      line_q  <= line_d;
    end
  end

  assign cmd_o = cmd;

endmodule

`default_nettype wire

// ===== rtl/core/b64e_queue.sv =====
// ---------------------------------------------------------------------------
// b64e_queue
// Two-entry command queue between the byte front end and the serializer.
// ---------------------------------------------------------------------------
`default_nettype none

module b64e_queue import b64e_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t push_cmd_i,
  input  wire logic pop_i,
  output cmd_t      head_o,
  output logic      full_o,
  output logic      empty_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/b64e_back.sv =====
// ---------------------------------------------------------------------------
// b64e_back
// Walks the head command one character per cycle, while the output is not stalled, into the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module b64e_back import b64e_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cmd_t       head_i,
  input  wire logic       empty_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_char_o,
  output logic            last_o
);

  logic [1:0] idx_q;
  logic       valid_q;
  logic [7:0] char_q;
  logic       last_q;
  logic       load;
  logic       at_end;

  // The output register refills whenever it is empty or being taken and a command is waiting.
  assign load   = !valid_q || !out_stall_i;
  assign at_end = (idx_q == head_i.cnt_m1);
  assign pop_o  = load && !empty_i && at_end;

  always_ff @(posedge clk_i) begin
    if (load && !empty_i) begin
      char_q <= head_i.chars[idx_q];
      last_q <= head_i.last && at_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else if (load) begin
      valid_q <= !empty_i;
      if (!empty_i) begin
        idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire
